@@ hw/rtl/lazy_shuffle_address_permuter_defines.svh @@
// Assertion macros for the lazy shuffle address permuter.
`ifndef LAZY_SHUFFLE_ADDRESS_PERMUTER_DEFINES_SVH
`define LAZY_SHUFFLE_ADDRESS_PERMUTER_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk while rst_n is high.
`define LSAP_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lsap assertion failed");
// Checked on every rising edge of clk, reset included.
`define LSAP_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("lsap assertion failed");
`else
`define LSAP_ASSERT(label, prop)
`define LSAP_ASSERT_ALWAYS(label, prop)
`endif
`endif

@@ hw/rtl/lsap_pkg.sv @@
// Shared widths, register indexes and state codes of the address permuter.
package lsap_pkg;

    localparam int RND_W     = 16;
    localparam int ADDR_W    = 64;
    localparam int OFF_W     = 12;
    localparam int SIZE_W    = 13;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_START = 2'd0,
        REG_RANGE_SIZE  = 2'd1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLR  = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_RD2  = 4'b0100,
        ST_WR   = 4'b1000
    } state_t;

endpackage

@@ hw/rtl/lazy_shuffle_address_permuter.sv @@
// Lazy Fisher-Yates address permuter built around one remap memory.
//
// Hands out every address of [range_start, range_start + range_size) exactly
// once in random order, one result per request transfer, then a zero address
// with done_res and exhausted set. In steady state the picked position and
// the cursor position are read one after the other through the single read
// port of the remap memory, and the write-back of the moved offset overlaps
// the first read of the next request. The cursor is updated before the next
// request is taken. After reset and after every range_size write the block
// clears the valid marks of all MAX_RANGE entries of the memory and takes no
// request meanwhile; configuration writes are always taken.
`include "lazy_shuffle_address_permuter_defines.svh"

module lazy_shuffle_address_permuter
    import lsap_pkg::*;
#(
    parameter int MAX_RANGE = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RND_W-1:0]     random_value,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    address,
    output logic [OFF_W-1:0]     offset,
    output logic                 done_res,
    output logic                 exhausted
);

    localparam int IDX_W  = $clog2(MAX_RANGE);
    localparam int MEM_W  = IDX_W + 1;
    localparam int PROD_W = RND_W + IDX_W;

    // Each entry holds a valid mark on top of the offset it stands for.
    logic [MEM_W-1:0]  mem_ram [MAX_RANGE];
    logic [MEM_W-1:0]  rd_data_reg;
    logic              fwd_hit_reg;
    logic [MEM_W-1:0]  fwd_data_reg;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  cursor_reg, cursor_next;
    logic              finished_reg, finished_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] range_start_reg;

    logic [IDX_W-1:0]  pos_reg;
    logic [IDX_W-1:0]  curs_at_reg;
    logic              last_reg;
    logic              exh_reg;
    logic [IDX_W-1:0]  picked_reg;

    logic [ADDR_W-1:0] address_reg;
    logic [OFF_W-1:0]  offset_reg;
    logic              done_reg;
    logic              exhausted_reg;

    logic              cfg_fire;
    logic              size_fire;
    logic              in_fire;
    logic              out_free;
    logic              wr_done;
    logic [PROD_W-1:0] prod;
    logic [IDX_W-1:0]  pos_pick;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [MEM_W-1:0]  wr_data;
    logic [MEM_W-1:0]  pos_entry;
    logic [IDX_W-1:0]  moved;
    logic [SIZE_W-1:0] size_raw;
    logic [IDX_W-1:0]  size_cursor;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign size_fire = cfg_fire && (cfg_index == REG_RANGE_SIZE);

    assign out_free = !out_valid_reg || out_ready;
    assign wr_done  = (state_reg == ST_WR) && out_free;
    assign in_ready = (state_reg == ST_IDLE) || wr_done;
    assign in_fire  = in_valid && in_ready;

    // The picked position is the high part of random_value * cursor.
    assign prod     = PROD_W'(random_value) * PROD_W'(cursor_reg);
    assign pos_pick = prod[PROD_W-1:RND_W];

    assign rd_en   = in_fire || (state_reg == ST_RD2);
    assign rd_addr = in_fire ? pos_pick : cursor_reg;

    assign pos_entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign moved     = rd_data_reg[IDX_W] ? rd_data_reg[IDX_W-1:0] : curs_at_reg;

    always_comb
    begin
        if (state_reg == ST_CLR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = (state_reg == ST_WR) && !last_reg && !exh_reg;
            wr_addr = pos_reg;
            wr_data = {1'b1, moved};
        end
    end

    // A read in the cycle of a write to the same entry sees the new data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_ram[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem_ram[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            fwd_data_reg <= wr_data;
        end
    end

    always_comb
    begin
        size_raw = cfg_data[SIZE_W-1:0];
        if (size_raw == '0)
        begin
            size_cursor = '0;
        end
        else if (32'(size_raw) > MAX_RANGE)
        begin
            size_cursor = IDX_W'(MAX_RANGE - 1);
        end
        else
        begin
            size_cursor = IDX_W'(size_raw - 1'b1);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cursor_next    = cursor_reg;
        finished_next  = finished_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(MAX_RANGE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_RD2;
                end
            end
            ST_RD2:
            begin
                state_next = ST_WR;
                if (!exh_reg)
                begin
                    if (last_reg)
                    begin
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        cursor_next = cursor_reg - 1'b1;
                    end
                end
            end
            ST_WR:
            begin
                if (wr_done)
                begin
                    out_valid_next = 1'b1;
                    state_next     = in_fire ? ST_RD2 : ST_IDLE;
                end
            end
            default:
            begin
                state_next   = ST_CLR;
                clr_cnt_next = '0;
            end
        endcase

        if (size_fire)
        begin
            state_next    = ST_CLR;
            clr_cnt_next  = '0;
            cursor_next   = size_cursor;
            finished_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLR;
            cursor_reg      <= '0;
            finished_reg    <= 1'b0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
            range_start_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            finished_reg  <= finished_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_fire && (cfg_index == REG_RANGE_START))
            begin
                range_start_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pos_reg     <= pos_pick;
            curs_at_reg <= cursor_reg;
            last_reg    <= (cursor_reg == '0);
            exh_reg     <= finished_reg;
        end
        if (state_reg == ST_RD2)
        begin
            // A position without a valid mark holds its own index.
            picked_reg <= pos_entry[IDX_W] ? pos_entry[IDX_W-1:0] : pos_reg;
        end
        if (wr_done)
        begin
            if (exh_reg)
            begin
                address_reg   <= '0;
                offset_reg    <= '0;
                done_reg      <= 1'b1;
                exhausted_reg <= 1'b1;
            end
            else
            begin
                address_reg   <= range_start_reg + ADDR_W'(picked_reg);
                offset_reg    <= OFF_W'(picked_reg);
                done_reg      <= last_reg;
                exhausted_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign address   = address_reg;
    assign offset    = offset_reg;
    assign done_res  = done_reg;
    assign exhausted = exhausted_reg;

    `LSAP_ASSERT(a_pick_below_cursor, (state_reg == ST_RD2 && !last_reg) |-> (pos_reg < cursor_reg))
    `LSAP_ASSERT(a_cursor_steps_down, (state_reg == ST_RD2 && !last_reg && !exh_reg && !size_fire) |=> (cursor_reg == IDX_W'($past(cursor_reg) - 1'b1)))
    `LSAP_ASSERT_ALWAYS(a_finish_on_last, $rose(finished_reg) |-> $past(last_reg))

endmodule
